// File: src/ntd_pkg.sv
`default_nettype none

package ntd_pkg;

    localparam int QUO_W  = 18;
    localparam int DIVR_W = 15;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int MS_W   = 19;

    localparam logic [QUO_W-1:0] DIVIDEND  = QUO_W'(60000 * 4);
    localparam logic [MS_W-1:0]  TEMPO0_MS = MS_W'(250);
    localparam logic [MS_W-1:0]  MS_FLOOR  = MS_W'(10);
    localparam logic [7:0]       DUR_MAX   = 8'd32;
    localparam logic [3:0]       OCT_MAX   = 4'd8;
    localparam logic [7:0]       DUR_DEF   = 8'd4;
    localparam logic [3:0]       OCT_DEF   = 4'd4;
    localparam logic [2:0]       DOTS_MAX  = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'd32;

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_DUR  = 3'd1;
    localparam logic [2:0] PH_LET  = 3'd2;
    localparam logic [2:0] PH_SHP  = 3'd3;
    localparam logic [2:0] PH_OCT  = 3'd4;
    localparam logic [2:0] PH_DOT  = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;
    localparam logic [2:0] PH_BAD  = 3'd7;

    localparam logic [1:0] ST_NOTE  = 2'd0;
    localparam logic [1:0] ST_PAUSE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam logic [2:0] REG_DEF_DURATION = 3'd0;
    localparam logic [2:0] REG_DEF_OCTAVE   = 3'd1;
    localparam logic [2:0] REG_TEMPO_BPM    = 3'd2;
    localparam logic [2:0] REG_MIN_FREQ     = 3'd3;
    localparam logic [2:0] REG_MAX_FREQ     = 3'd4;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } ntd_div_res_t;

    function automatic logic [15:0] tone_base(input logic [3:0] idx);
        logic [15:0] hz;
        case (idx)
            4'd0:    hz = 16'd262;
            4'd1:    hz = 16'd277;
            4'd2:    hz = 16'd294;
            4'd3:    hz = 16'd311;
            4'd4:    hz = 16'd330;
            4'd5:    hz = 16'd349;
            4'd6:    hz = 16'd370;
            4'd7:    hz = 16'd392;
            4'd8:    hz = 16'd415;
            4'd9:    hz = 16'd440;
            4'd10:   hz = 16'd466;
            4'd11:   hz = 16'd494;
            default: hz = 16'd0;
        endcase
        return hz;
    endfunction

    function automatic logic [3:0] letter_offset(input logic [2:0] letter);
        logic [3:0] offs;
        case (letter)
            3'd0:    offs = 4'd9;
            3'd1:    offs = 4'd11;
            3'd2:    offs = 4'd0;
            3'd3:    offs = 4'd2;
            3'd4:    offs = 4'd4;
            3'd5:    offs = 4'd5;
            3'd6:    offs = 4'd7;
            default: offs = 4'd0;
        endcase
        return offs;
    endfunction

endpackage

`default_nettype wire

// File: src/ntd_if.sv
`default_nettype none

interface ntd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_text;

    modport source (output valid, character, end_of_text, input ready);
    modport sink (input valid, character, end_of_text, output ready);
endinterface

interface ntd_note_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  semitone;
    logic [15:0] frequency_hz;
    logic [5:0]  duration_code;
    logic [2:0]  dot_count;
    logic [18:0] duration_ms;

    modport source (output valid, status, semitone, frequency_hz, duration_code, dot_count,
                    duration_ms, input ready);
    modport sink (input valid, status, semitone, frequency_hz, duration_code, dot_count,
                  duration_ms, output ready);
endinterface

interface ntd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/note_token_decoder.sv
// Note token decoder: turns a character stream of comma-separated note tokens
// into one note word per token.
// The chars channel takes one character word per cycle while the block is
// parsing; a token closes on a comma, a zero character, or end_of_text.
// Each closed token yields one word on the notes channel with status,
// semitone, clamped frequency, duration divisor, dot count and length in ms.
// The cfg channel writes the five registers; the user is to write them only
// while the block is idle, which it does not enforce; cfg is always ready.
// A character that does not close a token is absorbed in the idle state.
// A closing character passes the prep and start states, then the bit-serial
// divider that computes 240000 / (duration * bpm) at one quotient bit per
// cycle, then one dot step per dot extension, before its word is loaded out.
// Empty or bad tokens and tempo zero skip the divider and the dot steps.
// Chars is not ready while a token result is being computed.
// The note word sits in an output register; parsing of the next token goes on
// while it waits, and a new result waits for that register to empty.
// Reset clears the parser, drops any pending word and loads the register
// defaults 4, 4, 120, 20 and 20000.
`default_nettype none

module note_token_decoder
    import ntd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ntd_char_if.sink          chars,
    ntd_note_if.source        notes,
    ntd_cfg_if.sink           cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DOTS  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [3:0]  oct_reg, oct_next;
    logic        seen_reg, seen_next;
    logic [2:0]  letter_reg, letter_next;
    logic        pause_reg, pause_next;
    logic        sharp_reg, sharp_next;
    logic [2:0]  dots_reg, dots_next;

    logic [2:0]  fphase;
    logic [7:0]  flen;
    logic [3:0]  foct;
    logic        fseen;
    logic [2:0]  fletter;
    logic        fpause;
    logic        fsharp;
    logic [2:0]  fdots;

    logic [7:0]  def_dur_reg;
    logic [3:0]  def_oct_reg;
    logic [9:0]  bpm_reg;
    logic [15:0] fmin_reg;
    logic [15:0] fmax_reg;

    logic [1:0]       rstat_reg, rstat_next;
    logic [6:0]       rsemi_reg, rsemi_next;
    logic [15:0]      rfreq_reg, rfreq_next;
    logic [5:0]       rdur_reg, rdur_next;
    logic [2:0]       rdots_reg, rdots_next;
    logic [MS_W-1:0]  ms_reg, ms_next;
    logic [QUO_W-1:0] part_reg, part_next;
    logic [2:0]       dcnt_reg, dcnt_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  o_status_reg;
    logic [6:0]  o_semi_reg;
    logic [15:0] o_freq_reg;
    logic [5:0]  o_dur_reg;
    logic [2:0]  o_dots_reg;
    logic [18:0] o_ms_reg;
    logic        out_load;

    logic [7:0]  upper;
    logic        is_digit;
    logic        is_letter;
    logic [3:0]  digit;
    logic [11:0] len_sum;
    logic [7:0]  oct_sum;
    logic        is_close;

    logic [7:0]  dur_eff;
    logic [5:0]  dur_cl;
    logic [3:0]  oct_eff;
    logic [3:0]  oct_cl;
    logic [3:0]  offs;
    logic        wrap;
    logic [3:0]  oct_tone;
    logic [3:0]  idx;
    logic [6:0]  semi;
    logic [15:0] base;
    logic [15:0] shifted;
    logic [15:0] f_low;
    logic [15:0] f_clamp;

    logic              div_start;
    logic [15:0]       prod;
    ntd_div_res_t      div_res;
    logic [QUO_W-1:0]  part_half;

    ntd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (prod[DIVR_W-1:0]),
        .res     (div_res)
    );

    always_comb
    begin
        upper = chars.character;
        if (chars.character inside {[CH_LA:CH_LZ]})
        begin
            upper = chars.character - CASE_GAP;
        end
        is_digit  = chars.character inside {[CH_0:CH_9]};
        is_letter = (upper == CH_UP) || (upper inside {[CH_UA:CH_UG]});
        digit     = chars.character[3:0];
        len_sum   = ({4'd0, len_reg} << 3) + ({4'd0, len_reg} << 1) + {8'd0, digit};
        oct_sum   = ({4'd0, oct_reg} << 3) + ({4'd0, oct_reg} << 1) + {4'd0, digit};

        fphase  = phase_reg;
        flen    = len_reg;
        foct    = oct_reg;
        fseen   = seen_reg;
        fletter = letter_reg;
        fpause  = pause_reg;
        fsharp  = sharp_reg;
        fdots   = dots_reg;

        case (phase_reg)
            PH_LEAD, PH_DUR:
            begin
                if (phase_reg == PH_LEAD
                    && (chars.character == CH_SPACE || chars.character == CH_TAB))
                begin
                    fphase = phase_reg;
                end
                else if (is_digit)
                begin
                    flen   = (len_sum > 12'd255) ? 8'd255 : len_sum[7:0];
                    fphase = PH_DUR;
                end
                else if (is_letter)
                begin
                    fpause  = (upper == CH_UP);
                    fletter = (upper == CH_UP) ? 3'd0 : (upper[2:0] - 3'd1);
                    fphase  = PH_LET;
                end
                else
                begin
                    fphase = PH_BAD;
                end
            end
            PH_LET, PH_SHP, PH_OCT:
            begin
                if (phase_reg == PH_LET
                    && (chars.character == CH_HASH || chars.character == CH_UNDER))
                begin
                    fsharp = 1'b1;
                    fphase = PH_SHP;
                end
                else if (is_digit)
                begin
                    foct   = (oct_sum > 8'd15) ? 4'd15 : oct_sum[3:0];
                    fseen  = 1'b1;
                    fphase = PH_OCT;
                end
                else if (chars.character == CH_DOT)
                begin
                    fdots  = 3'd1;
                    fphase = PH_DOT;
                end
                else
                begin
                    fphase = PH_DONE;
                end
            end
            PH_DOT:
            begin
                if (chars.character == CH_DOT)
                begin
                    if (dots_reg < DOTS_MAX)
                    begin
                        fdots = dots_reg + 3'd1;
                    end
                end
                else
                begin
                    fphase = PH_DONE;
                end
            end
            default:
            begin
                fphase = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        dur_eff  = (len_reg != 8'd0) ? len_reg
                 : ((def_dur_reg != 8'd0) ? def_dur_reg : DUR_DEF);
        dur_cl   = (dur_eff > DUR_MAX) ? DUR_MAX[5:0] : dur_eff[5:0];
        oct_eff  = seen_reg ? oct_reg : ((def_oct_reg != 4'd0) ? def_oct_reg : OCT_DEF);
        oct_cl   = (oct_eff > OCT_MAX) ? OCT_MAX : oct_eff;
        offs     = letter_offset(letter_reg) + {3'd0, sharp_reg};
        wrap     = (offs == 4'd12);
        oct_tone = wrap ? (oct_cl + 4'd1) : oct_cl;
        idx      = wrap ? 4'd0 : offs;
        semi     = ({3'd0, oct_cl} << 3) + ({3'd0, oct_cl} << 2) + {3'd0, offs};
        base     = tone_base(idx);
        if (oct_tone >= 4'd4)
        begin
            shifted = base << (oct_tone - 4'd4);
        end
        else
        begin
            shifted = base >> (4'd4 - oct_tone);
        end
        f_low   = (shifted < fmin_reg) ? fmin_reg : shifted;
        f_clamp = (f_low > fmax_reg) ? fmax_reg : f_low;
        prod      = {10'd0, rdur_reg} * {6'd0, bpm_reg};
        part_half = {1'b0, part_reg[QUO_W-1:1]};
        is_close  = (chars.character == CH_COMMA) || (chars.character == CH_NUL);
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        len_next    = len_reg;
        oct_next    = oct_reg;
        seen_next   = seen_reg;
        letter_next = letter_reg;
        pause_next  = pause_reg;
        sharp_next  = sharp_reg;
        dots_next   = dots_reg;
        rstat_next  = rstat_reg;
        rsemi_next  = rsemi_reg;
        rfreq_next  = rfreq_reg;
        rdur_next   = rdur_reg;
        rdots_next  = rdots_reg;
        ms_next     = ms_reg;
        part_next   = part_reg;
        dcnt_next   = dcnt_reg;
        div_start   = 1'b0;
        out_load    = 1'b0;
        out_valid_next = out_valid_reg && !notes.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (chars.valid)
                begin
                    if (!is_close)
                    begin
                        phase_next  = fphase;
                        len_next    = flen;
                        oct_next    = foct;
                        seen_next   = fseen;
                        letter_next = fletter;
                        pause_next  = fpause;
                        sharp_next  = fsharp;
                        dots_next   = fdots;
                    end
                    if (is_close || chars.end_of_text)
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                rsemi_next = '0;
                rfreq_next = '0;
                rdur_next  = '0;
                rdots_next = '0;
                ms_next    = '0;
                if (phase_reg == PH_LEAD || phase_reg == PH_DUR)
                begin
                    rstat_next = ST_EMPTY;
                    state_next = S_OUT;
                end
                else if (phase_reg == PH_BAD)
                begin
                    rstat_next = ST_BAD;
                    state_next = S_OUT;
                end
                else
                begin
                    rstat_next = pause_reg ? ST_PAUSE : ST_NOTE;
                    rsemi_next = pause_reg ? 7'd0 : semi;
                    rfreq_next = pause_reg ? 16'd0 : f_clamp;
                    rdur_next  = dur_cl;
                    rdots_next = dots_reg;
                    if (bpm_reg == 10'd0)
                    begin
                        ms_next    = TEMPO0_MS;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
                phase_next  = PH_LEAD;
                len_next    = '0;
                oct_next    = '0;
                seen_next   = 1'b0;
                letter_next = '0;
                pause_next  = 1'b0;
                sharp_next  = 1'b0;
                dots_next   = '0;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    ms_next    = {1'b0, div_res.quotient};
                    part_next  = div_res.quotient;
                    dcnt_next  = '0;
                    state_next = S_DOTS;
                end
            end
            S_DOTS:
            begin
                if (dcnt_reg == rdots_reg)
                begin
                    ms_next    = (ms_reg < MS_FLOOR) ? MS_FLOOR : ms_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    part_next = part_half;
                    ms_next   = ms_reg + {1'b0, part_half};
                    dcnt_next = dcnt_reg + 3'd1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || notes.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_LEAD;
            len_reg       <= '0;
            oct_reg       <= '0;
            seen_reg      <= 1'b0;
            letter_reg    <= '0;
            pause_reg     <= 1'b0;
            sharp_reg     <= 1'b0;
            dots_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            def_dur_reg   <= 8'd4;
            def_oct_reg   <= 4'd4;
            bpm_reg       <= 10'd120;
            fmin_reg      <= 16'd20;
            fmax_reg      <= 16'd20000;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            oct_reg       <= oct_next;
            seen_reg      <= seen_next;
            letter_reg    <= letter_next;
            pause_reg     <= pause_next;
            sharp_reg     <= sharp_next;
            dots_reg      <= dots_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_DEF_DURATION: def_dur_reg <= cfg.data[7:0];
                    REG_DEF_OCTAVE:   def_oct_reg <= cfg.data[3:0];
                    REG_TEMPO_BPM:    bpm_reg     <= cfg.data[9:0];
                    REG_MIN_FREQ:     fmin_reg    <= cfg.data;
                    REG_MAX_FREQ:     fmax_reg    <= cfg.data;
                    default:          def_dur_reg <= def_dur_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rstat_reg <= rstat_next;
        rsemi_reg <= rsemi_next;
        rfreq_reg <= rfreq_next;
        rdur_reg  <= rdur_next;
        rdots_reg <= rdots_next;
        ms_reg    <= ms_next;
        part_reg  <= part_next;
        if (out_load)
        begin
            o_status_reg <= rstat_reg;
            o_semi_reg   <= rsemi_reg;
            o_freq_reg   <= rfreq_reg;
            o_dur_reg    <= rdur_reg;
            o_dots_reg   <= rdots_reg;
            o_ms_reg     <= ms_reg;
        end
    end

    assign chars.ready         = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign notes.valid         = out_valid_reg;
    assign notes.status        = o_status_reg;
    assign notes.semitone      = o_semi_reg;
    assign notes.frequency_hz  = o_freq_reg;
    assign notes.duration_code = o_dur_reg;
    assign notes.dot_count     = o_dots_reg;
    assign notes.duration_ms   = o_ms_reg;

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        notes.valid && (notes.status == ST_EMPTY || notes.status == ST_BAD)
        |-> notes.semitone == 7'd0 && notes.frequency_hz == 16'd0
            && notes.duration_ms == 19'd0 && notes.dot_count == 3'd0)
        else $error("failed token carries nonzero fields");

    a_note_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        notes.valid && (notes.status == ST_NOTE || notes.status == ST_PAUSE)
        |-> notes.duration_ms >= MS_FLOOR && notes.duration_code != 6'd0
            && notes.duration_code <= DUR_MAX[5:0] && notes.dot_count <= DOTS_MAX)
        else $error("note word out of range");

    a_pause_silent: assert property (@(posedge clk) disable iff (!rst_n)
        notes.valid && notes.status == ST_PAUSE |-> notes.frequency_hz == 16'd0)
        else $error("pause with nonzero frequency");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV && $past(state_reg) == S_DIV)
        else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

// File: src/ntd_div.sv
`default_nettype none

module ntd_div
    import ntd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVR_W-1:0] divisor,
    output ntd_div_res_t      res
);

    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVR_W:0]   trial;
    logic [DIVR_W:0]   diff;
    logic              qbit;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        qbit      = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = DIVIDEND;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], qbit};
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

`default_nettype wire

// File: tb/tb_note_token_decoder.sv
`timescale 1ns / 100ps

module tb_note_token_decoder;
    import ntd_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 150;

    localparam int TONE_HZ_OCT4 [12] = '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440,
                                         466, 494};
    localparam int LETTER_SEMI [7] = '{9, 11, 0, 2, 4, 5, 7};

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } char_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  semitone;
        logic [15:0] frequency_hz;
        logic [5:0]  duration_code;
        logic [2:0]  dot_count;
        logic [18:0] duration_ms;
    } note_word_t;

    class note_event_model;
        logic [7:0]  dflt_len;
        logic [3:0]  dflt_oct;
        logic [9:0]  bpm;
        logic [15:0] lo_hz;
        logic [15:0] hi_hz;

        logic [2:0] phase;
        int         len_acc;
        int         oct_acc;
        bit         oct_seen;
        int         letter;
        bit         is_pause;
        bit         sharp;
        int         dots;

        note_word_t pending_notes[$];
        int         errors;

        function new();
            dflt_len = 8'd4;
            dflt_oct = 4'd4;
            bpm = 10'd120;
            lo_hz = 16'd20;
            hi_hz = 16'd20000;
            errors = 0;
            clear_token();
        endfunction

        function void clear_token();
            phase = PH_LEAD;
            len_acc = 0;
            oct_acc = 0;
            oct_seen = 0;
            letter = 0;
            is_pause = 0;
            sharp = 0;
            dots = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_DEF_DURATION: dflt_len = data[7:0];
                REG_DEF_OCTAVE:   dflt_oct = data[3:0];
                REG_TEMPO_BPM:    bpm = data[9:0];
                REG_MIN_FREQ:     lo_hz = data;
                REG_MAX_FREQ:     hi_hz = data;
                default:          ;
            endcase
        endfunction

        function void parse_char(logic [7:0] c);
            logic [7:0] u;
            bit         digit;
            digit = (c >= CH_0) && (c <= CH_9);
            u = (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
            case (phase)
                PH_LEAD, PH_DUR:
                begin
                    if (phase == PH_LEAD && (c == CH_SPACE || c == CH_TAB))
                    begin
                    end
                    else if (digit)
                    begin
                        len_acc = len_acc * 10 + (c - CH_0);
                        if (len_acc > 255)
                            len_acc = 255;
                        phase = PH_DUR;
                    end
                    else if (u == CH_UP)
                    begin
                        is_pause = 1;
                        letter = 0;
                        phase = PH_LET;
                    end
                    else if (u >= CH_UA && u <= CH_UG)
                    begin
                        is_pause = 0;
                        letter = u - CH_UA;
                        phase = PH_LET;
                    end
                    else
                        phase = PH_BAD;
                end
                PH_LET, PH_SHP, PH_OCT:
                begin
                    if (phase == PH_LET && (c == CH_HASH || c == CH_UNDER))
                    begin
                        sharp = 1;
                        phase = PH_SHP;
                    end
                    else if (digit)
                    begin
                        oct_acc = oct_acc * 10 + (c - CH_0);
                        if (oct_acc > 15)
                            oct_acc = 15;
                        oct_seen = 1;
                        phase = PH_OCT;
                    end
                    else if (c == CH_DOT)
                    begin
                        dots = 1;
                        phase = PH_DOT;
                    end
                    else
                        phase = PH_DONE;
                end
                PH_DOT:
                begin
                    if (c != CH_DOT)
                        phase = PH_DONE;
                    else if (dots < 4)
                        dots++;
                end
                default: ;
            endcase
        endfunction

        function void close_token();
            note_word_t w;
            int         dur;
            int         oct;
            int         semi;
            int         octv;
            int         hz;
            int         ms;
            int         part;
            w = '0;
            if (phase == PH_LEAD || phase == PH_DUR)
                w.status = ST_EMPTY;
            else if (phase == PH_BAD)
                w.status = ST_BAD;
            else
            begin
                dur = (len_acc != 0) ? len_acc : ((dflt_len != 0) ? int'(dflt_len) : 4);
                if (dur > 32)
                    dur = 32;
                oct = oct_seen ? oct_acc : ((dflt_oct != 0) ? int'(dflt_oct) : 4);
                if (oct > 8)
                    oct = 8;
                semi = 0;
                hz = 0;
                if (is_pause)
                    w.status = ST_PAUSE;
                else
                begin
                    w.status = ST_NOTE;
                    semi = oct * 12 + LETTER_SEMI[letter] + int'(sharp);
                    octv = semi / 12;
                    if (octv >= 4)
                        hz = TONE_HZ_OCT4[semi % 12] << (octv - 4);
                    else
                        hz = TONE_HZ_OCT4[semi % 12] >> (4 - octv);
                    if (hz < lo_hz)
                        hz = lo_hz;
                    if (hz > hi_hz)
                        hz = hi_hz;
                end
                if (bpm == 0)
                    ms = 250;
                else
                begin
                    ms = 240000 / (dur * int'(bpm));
                    part = ms;
                    repeat (dots)
                    begin
                        part = part / 2;
                        ms += part;
                    end
                    if (ms < 10)
                        ms = 10;
                end
                w.semitone = 7'(semi);
                w.frequency_hz = 16'(hz);
                w.duration_code = 6'(dur);
                w.dot_count = 3'(dots);
                w.duration_ms = 19'(ms);
            end
            pending_notes.push_back(w);
            clear_token();
        endfunction

        function void take_char(logic [7:0] c, logic eot);
            if (c == CH_COMMA || c == CH_NUL)
                close_token();
            else
            begin
                parse_char(c);
                if (eot)
                    close_token();
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_note(note_word_t got);
            note_word_t want;
            if (pending_notes.size() == 0)
            begin
                $error("note word with no token pending: status %0d, semitone %0d",
                       got.status, got.semitone);
                errors++;
                return;
            end
            want = pending_notes.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("semitone", want.semitone, got.semitone);
            compare_field("frequency_hz", want.frequency_hz, got.frequency_hz);
            compare_field("duration_code", want.duration_code, got.duration_code);
            compare_field("dot_count", want.dot_count, got.dot_count);
            compare_field("duration_ms", want.duration_ms, got.duration_ms);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ntd_char_if chars_if ();
    ntd_note_if notes_if ();
    ntd_cfg_if  cfg_if ();

    note_event_model model;
    char_word_t      text_q[$];
    logic [15:0]     reg_plan [5];
    bit              calm;
    bit              hold_off;
    int              idle_cycles;

    note_token_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .notes (notes_if),
        .cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    function automatic void push_char(logic [7:0] c, logic eot);
        char_word_t w;
        w.ch = c;
        w.eot = eot;
        text_q.push_back(w);
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], 1'b0);
    endfunction

    function automatic void push_number(int n);
        push_str($sformatf("%0d", n));
    endfunction

    function automatic void add_close();
        case ($urandom_range(3))
            0: push_char(CH_COMMA, 1'b0);
            1: push_char(CH_NUL, 1'b0);
            2: push_char(CH_COMMA, 1'b1);
            default:
            begin
                if (text_q.size() == 0)
                    push_char(CH_COMMA, 1'b0);
                else
                    text_q[text_q.size() - 1].eot = 1'b1;
            end
        endcase
    endfunction

    function automatic void add_token();
        string      letters;
        int         k;
        logic [7:0] junk;
        letters = "ABCDEFGPabcdefgp";
        if ($urandom_range(9) < 3)
            repeat ($urandom_range(1, 2))
                push_char($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
        k = $urandom_range(19);
        if (k < 8)
            push_number(1 << $urandom_range(5));
        else if (k < 10)
            push_number($urandom_range(0, 999));
        else if (k == 10)
            push_number($urandom_range(1000, 99999));
        push_char(letters[$urandom_range(15)], 1'b0);
        if ($urandom_range(9) < 3)
            push_char($urandom_range(1) ? CH_HASH : CH_UNDER, 1'b0);
        k = $urandom_range(9);
        if (k < 4)
            push_number($urandom_range(0, 9));
        else if (k == 4)
            push_number($urandom_range(10, 9999));
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 6))
                push_char(CH_DOT, 1'b0);
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3))
            begin
                do
                    junk = 8'($urandom_range(1, 255));
                while (junk == CH_COMMA);
                push_char(junk, 1'b0);
            end
        add_close();
    endfunction

    function automatic void add_noise();
        repeat ($urandom_range(1, 5))
            push_char(8'($urandom_range(255)), $urandom_range(9) == 0);
        add_close();
    endfunction

    function automatic void set_plan(int dur, int oct, int tempo, int lo, int hi);
        reg_plan[REG_DEF_DURATION] = 16'(dur);
        reg_plan[REG_DEF_OCTAVE] = 16'(oct);
        reg_plan[REG_TEMPO_BPM] = 16'(tempo);
        reg_plan[REG_MIN_FREQ] = 16'(lo);
        reg_plan[REG_MAX_FREQ] = 16'(hi);
    endfunction

    task automatic apply_settings();
        for (int i = REG_DEF_DURATION; i <= REG_MAX_FREQ; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= 3'(i);
            cfg_if.data <= reg_plan[i];
            do @(posedge clk); while (!cfg_if.ready);
            model.write_reg(3'(i), reg_plan[i]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_text();
        char_word_t w;
        while (text_q.size() != 0)
        begin
            w = text_q.pop_front();
            if (!calm && $urandom_range(99) < 17)
            begin
                chars_if.valid <= 1'b0;
                @(posedge clk);
            end
            chars_if.valid <= 1'b1;
            chars_if.character <= w.ch;
            chars_if.end_of_text <= w.eot;
            do @(posedge clk); while (!chars_if.ready);
            model.take_char(w.ch, w.eot);
        end
        chars_if.valid <= 1'b0;
    endtask

    task automatic settle();
        while (model.pending_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && notes_if.valid && notes_if.ready)
            model.check_note('{notes_if.status, notes_if.semitone, notes_if.frequency_hz,
                               notes_if.duration_code, notes_if.dot_count,
                               notes_if.duration_ms});
    end

    always @(posedge clk)
    begin
        if ((chars_if.valid && chars_if.ready) || (notes_if.valid && notes_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        notes_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                notes_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (calm)
                notes_if.ready <= 1'b1;
            else
                notes_if.ready <= ($urandom_range(99) >= 17);
        end
    end

    initial
    begin
        model = new();
        idle_cycles = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        chars_if.valid = 1'b0;
        chars_if.character = CH_NUL;
        chars_if.end_of_text = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_DEF_DURATION;
        cfg_if.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty token, bad byte, blank after digits, saturated numbers with
        // dots, a pause closed by end_of_text, then a low octave with trailing
        // text closed by a comma that also carries end_of_text.
        push_char(CH_COMMA, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(CH_COMMA, 1'b0);
        push_str("1 c,");
        push_str("999b#99.....");
        push_char(CH_NUL, 1'b0);
        push_char("p", 1'b1);
        push_str("\tc0z");
        push_char(CH_COMMA, 1'b1);
        send_text();
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_plan(0, 0, 0, 0, 0);
                1: set_plan(255, 15, 1023, 65535, 65535);
                2: set_plan(8, 5, 60, 3000, 400);
                3: set_plan(1, 1, 1, 0, 65535);
                4: set_plan(32, 8, 63, 20, 20000);
                default:
                    set_plan($urandom_range(255), $urandom_range(15),
                             $urandom_range(1) ? $urandom_range(40, 300) : $urandom_range(1023),
                             $urandom_range(600), $urandom_range(200, 65535));
            endcase
            apply_settings();
            calm = (ph == 3);
            if (ph == 2)
                hold_off = 1'b1;
            while (text_q.size() < PHASE_WORDS)
            begin
                if ($urandom_range(99) < 85)
                    add_token();
                else
                    add_noise();
            end
            send_text();
            settle();
        end

        if (model.errors == 0 && model.pending_notes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: note_token_decoder.f
src/ntd_pkg.sv
src/ntd_if.sv
src/ntd_div.sv
src/note_token_decoder.sv
tb/tb_note_token_decoder.sv
